>>> src/esc_pkg.sv
`default_nettype none
package esc_pkg;

	typedef enum logic [3:0] {
		ST_INIT        = 4'd0,
		ST_CHECK       = 4'd1,
		ST_IDLE        = 4'd2,
		ST_READY       = 4'd3,
		ST_TEST        = 4'd4,
		ST_START       = 4'd5,
		ST_START_FORCE = 4'd6,
		ST_RUN         = 4'd7,
		ST_FORCE       = 4'd8,
		ST_SUPP        = 4'd9,
		ST_ERROR       = 4'd10
	} main_state_t;

	typedef enum logic [1:0] {
		PULSE_NONE  = 2'd0,
		PULSE_START = 2'd1,
		PULSE_STOP  = 2'd2
	} pulse_t;

	typedef enum logic [1:0] {
		REF_SEL_NONE    = 2'd0,
		REF_SEL_TEST    = 2'd1,
		REF_SEL_FORCING = 2'd2,
		REF_SEL_RUN     = 2'd3
	} ref_sel_t;

	// sub-sequencer step positions
	localparam logic [1:0] STEP_ENTER = 2'd0;
	localparam logic [1:0] STEP_WAIT1 = 2'd1;
	localparam logic [1:0] STEP_WAIT2 = 2'd2;
	localparam logic [1:0] STEP_DONE  = 2'd3;

	typedef struct packed {
		logic cmd_test;
		logic cmd_run;
		logic cmd_force;
		logic cmd_error;
		logic mains_volt_ok;
		logic mains_freq_ok;
		logic cell_volt_ok;
		logic field_on_flag;
		logic forcing_done;
		logic suppression_done;
		logic start_resistor_req;
	} req_item_t;

	typedef struct packed {
		logic [3:0] main_state_out;
		logic       drive_enable;
		logic [1:0] current_ref_select;
		logic       start_resistor_cmd;
		logic [1:0] start_counter_ctl;
		logic [1:0] forcing_timers_ctl;
		logic [1:0] suppression_timer_ctl;
		logic       manual_ref_preset;
	} rsp_item_t;

	// handshake between the output buffer and the input stage
	typedef struct packed {
		logic full;
		logic occupied;
	} buf_status_t;

endpackage
`default_nettype wire

>>> src/esc_step.sv
`default_nettype none
module esc_step (
	input  wire                    clk,
	input  wire                    arst_n,
	input  wire                    fire,
	input  esc_pkg::req_item_t     item,
	output esc_pkg::rsp_item_t     result,
	output esc_pkg::main_state_t   state
);

	esc_pkg::main_state_t state_q, state_d;
	logic                 entry_q;
	logic [1:0]           check_step_q, check_step_d;
	logic [1:0]           idle_step_q, idle_step_d;
	logic [1:0]           chk_cur, idle_cur;

	esc_pkg::pulse_t   cnt_ctl, frc_ctl, sup_ctl;
	esc_pkg::ref_sel_t sel;
	logic              enable, preset;

	assign chk_cur  = entry_q ? esc_pkg::STEP_ENTER : check_step_q;
	assign idle_cur = entry_q ? esc_pkg::STEP_ENTER : idle_step_q;

	// next state and sub-sequencer steps
	always_comb begin
		state_d      = state_q;
		check_step_d = check_step_q;
		idle_step_d  = idle_step_q;
		case (state_q)
			esc_pkg::ST_INIT: state_d = esc_pkg::ST_CHECK;
			esc_pkg::ST_CHECK: begin
				check_step_d = chk_cur;
				case (chk_cur)
					esc_pkg::STEP_ENTER: check_step_d = esc_pkg::STEP_WAIT1;
					esc_pkg::STEP_WAIT1: begin
						if (item.mains_volt_ok) check_step_d = esc_pkg::STEP_WAIT2;
					end
					esc_pkg::STEP_WAIT2: begin
						if (item.mains_freq_ok) check_step_d = esc_pkg::STEP_DONE;
					end
					default: state_d = esc_pkg::ST_IDLE;
				endcase
			end
			esc_pkg::ST_IDLE: begin
				idle_step_d = idle_cur;
				case (idle_cur)
					esc_pkg::STEP_ENTER: idle_step_d = esc_pkg::STEP_WAIT1;
					esc_pkg::STEP_WAIT1: begin
						if (item.cell_volt_ok) idle_step_d = esc_pkg::STEP_WAIT2;
					end
					default: state_d = esc_pkg::ST_READY;
				endcase
				if (item.cmd_test) state_d = esc_pkg::ST_TEST;
			end
			esc_pkg::ST_READY: begin
				if (item.cmd_test) state_d = esc_pkg::ST_TEST;
				if (item.cmd_run) state_d = esc_pkg::ST_START;
			end
			esc_pkg::ST_TEST: begin
				if (!item.cmd_test) state_d = esc_pkg::ST_INIT;
			end
			esc_pkg::ST_START: begin
				if (item.field_on_flag) state_d = esc_pkg::ST_START_FORCE;
			end
			esc_pkg::ST_START_FORCE: begin
				if (item.forcing_done) state_d = esc_pkg::ST_RUN;
			end
			esc_pkg::ST_RUN: begin
				if (item.cmd_force) state_d = esc_pkg::ST_FORCE;
				if (!item.cmd_run) state_d = esc_pkg::ST_SUPP;
			end
			esc_pkg::ST_FORCE: begin
				if (!item.cmd_force) state_d = esc_pkg::ST_RUN;
			end
			esc_pkg::ST_SUPP: begin
				if (item.suppression_done) state_d = esc_pkg::ST_INIT;
			end
			esc_pkg::ST_ERROR: begin
				if (!item.cmd_error) state_d = esc_pkg::ST_INIT;
			end
			default: state_d = esc_pkg::ST_INIT;
		endcase
		// error overrides whatever the handler picked
		if (item.cmd_error) state_d = esc_pkg::ST_ERROR;
	end

	// per-state outputs and entry/exit pulses (stop wins over start)
	always_comb begin
		cnt_ctl = esc_pkg::PULSE_NONE;
		frc_ctl = esc_pkg::PULSE_NONE;
		sup_ctl = esc_pkg::PULSE_NONE;
		enable  = 1'b0;
		preset  = 1'b0;
		sel     = esc_pkg::REF_SEL_NONE;
		case (state_q)
			esc_pkg::ST_TEST: begin
				enable = 1'b1;
				sel    = esc_pkg::REF_SEL_TEST;
			end
			esc_pkg::ST_START: begin
				if (entry_q) cnt_ctl = esc_pkg::PULSE_START;
				if (item.field_on_flag) cnt_ctl = esc_pkg::PULSE_STOP;
			end
			esc_pkg::ST_START_FORCE: begin
				enable = 1'b1;
				sel    = esc_pkg::REF_SEL_FORCING;
				if (entry_q) frc_ctl = esc_pkg::PULSE_START;
				if (item.forcing_done) frc_ctl = esc_pkg::PULSE_STOP;
			end
			esc_pkg::ST_RUN: begin
				enable = 1'b1;
				sel    = esc_pkg::REF_SEL_RUN;
				preset = entry_q;
			end
			esc_pkg::ST_FORCE: begin
				enable = 1'b1;
				sel    = esc_pkg::REF_SEL_FORCING;
			end
			esc_pkg::ST_SUPP: begin
				enable = 1'b1;
				if (entry_q) sup_ctl = esc_pkg::PULSE_START;
				if (item.suppression_done) sup_ctl = esc_pkg::PULSE_STOP;
			end
			default: begin
				enable = 1'b0;
			end
		endcase
	end

	always_comb begin
		result.main_state_out        = state_q;
		result.drive_enable          = enable;
		result.current_ref_select    = sel;
		result.start_resistor_cmd    = item.start_resistor_req;
		result.start_counter_ctl     = cnt_ctl;
		result.forcing_timers_ctl    = frc_ctl;
		result.suppression_timer_ctl = sup_ctl;
		result.manual_ref_preset     = preset;
	end

	assign state = state_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= esc_pkg::ST_INIT;
			entry_q      <= 1'b1;
			check_step_q <= esc_pkg::STEP_ENTER;
			idle_step_q  <= esc_pkg::STEP_ENTER;
		end else if (fire) begin
			state_q      <= state_d;
			entry_q      <= (state_d != state_q);
			check_step_q <= check_step_d;
			idle_step_q  <= idle_step_d;
		end
	end

endmodule
`default_nettype wire

>>> src/esc_out_buf.sv
`default_nettype none
module esc_out_buf (
	input  wire                  clk,
	input  wire                  arst_n,
	input  wire                  push,
	input  esc_pkg::rsp_item_t   push_data,
	output esc_pkg::buf_status_t status,
	output logic                 rsp_valid,
	input  wire                  rsp_stall,
	output esc_pkg::rsp_item_t   rsp_data
);

	logic               out_valid_q, skid_valid_q;
	esc_pkg::rsp_item_t out_q, skid_q;
	logic               pop;

	assign pop       = out_valid_q && !rsp_stall;
	assign rsp_valid = out_valid_q;
	assign rsp_data  = out_q;

	assign status.full     = skid_valid_q;
	assign status.occupied = out_valid_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q  <= 1'b0;
			skid_valid_q <= 1'b0;
		end else begin
			if (skid_valid_q) begin
				// push is held off while the skid slot is taken
				if (pop) begin
					out_valid_q  <= 1'b1;
					skid_valid_q <= 1'b0;
				end
			end else if (push) begin
				if (out_valid_q && !pop) begin
					skid_valid_q <= 1'b1;
				end else begin
					out_valid_q <= 1'b1;
				end
			end else if (pop) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (skid_valid_q) begin
			if (pop) out_q <= skid_q;
		end else if (push) begin
			if (out_valid_q && !pop) skid_q <= push_data;
			else out_q <= push_data;
		end
	end

endmodule
`default_nettype wire

>>> src/excitation_sequence_controller.sv
`default_nettype none
// Channel   Direction  Handshake               Payload
// request   in         req_valid / req_stall   req_data  (esc_pkg::req_item_t)
// response  out        rsp_valid / rsp_stall   rsp_data  (esc_pkg::rsp_item_t)
//
// One tick per cycle sustained while rsp_stall stays low: a request lands in
// the input register, the state update runs from there into a two-entry
// output buffer. The response passes through the input register and then
// the output buffer before rsp_valid rises.
// Reset puts the sequencer in init with the entry flag set, both buffers empty.
// req_stall is high only while the input register holds a request and the
// output buffer's skid slot holds a response.
module excitation_sequence_controller (
	input  wire                 clk,
	input  wire                 arst_n,
	input  wire                 req_valid,
	output logic                req_stall,
	input  esc_pkg::req_item_t  req_data,
	output logic                rsp_valid,
	input  wire                 rsp_stall,
	output esc_pkg::rsp_item_t  rsp_data
);

	esc_pkg::req_item_t   item_s1;
	logic                 valid_s1;
	logic                 adv_s1;
	logic                 req_fire;
	esc_pkg::rsp_item_t   result;
	esc_pkg::main_state_t state;
	esc_pkg::buf_status_t buf_status;

	assign adv_s1    = valid_s1 && !buf_status.full;
	assign req_stall = valid_s1 && buf_status.full;
	assign req_fire  = req_valid && !req_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (req_fire) begin
			valid_s1 <= 1'b1;
		end else if (adv_s1) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (req_fire) item_s1 <= req_data;
	end

	esc_step u_step (
		.clk    (clk),
		.arst_n (arst_n),
		.fire   (adv_s1),
		.item   (item_s1),
		.result (result),
		.state  (state)
	);

	esc_out_buf u_out_buf (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (adv_s1),
		.push_data (result),
		.status    (buf_status),
		.rsp_valid (rsp_valid),
		.rsp_stall (rsp_stall),
		.rsp_data  (rsp_data)
	);

	// a stored skid entry always sits behind a valid head
	assert property (@(posedge clk) disable iff (!arst_n)
		buf_status.full |-> buf_status.occupied)
		else $error("skid entry without head entry");

	// a processed error request lands the sequencer in error
	assert property (@(posedge clk) disable iff (!arst_n)
		(adv_s1 && item_s1.cmd_error) |=> (state == esc_pkg::ST_ERROR))
		else $error("error command did not take priority");

	// drive enable only in the energized states
	assert property (@(posedge clk) disable iff (!arst_n)
		(rsp_valid && rsp_data.drive_enable) |->
		((rsp_data.main_state_out == esc_pkg::ST_TEST) ||
		 (rsp_data.main_state_out == esc_pkg::ST_START_FORCE) ||
		 (rsp_data.main_state_out == esc_pkg::ST_RUN) ||
		 (rsp_data.main_state_out == esc_pkg::ST_FORCE) ||
		 (rsp_data.main_state_out == esc_pkg::ST_SUPP)))
		else $error("drive enabled in a de-energized state");

	// the sequencer only moves when a request leaves the input register
	assert property (@(posedge clk) disable iff (!arst_n)
		!adv_s1 |=> $stable(state))
		else $error("state changed without a request");

endmodule
`default_nettype wire
